// ===== design/opfe_pkg.sv =====
// ----------------------------------------------------------------------------
// opfe_pkg
// Shared types, codes and decode functions of the operator panel frame engine.
// ----------------------------------------------------------------------------
package opfe_pkg;

    // link codes
    localparam logic [7:0] CODE_DC1     = 8'h11;
    localparam logic [7:0] CODE_ACK     = 8'hb0;
    localparam logic [7:0] CODE_NAK     = 8'hc0;
    localparam logic [7:0] CODE_RELEASE = 8'haf;

    // frame commands
    localparam logic [7:0] OP_LCD = 8'ha1;
    localparam logic [7:0] OP_LED = 8'hac;
    localparam logic [7:0] OP_RST = 8'hb1;

    // lcd arrow substitution
    localparam logic [7:0] CHR_LEFT_IN   = 8'h12;
    localparam logic [7:0] CHR_RIGHT_IN  = 8'h13;
    localparam logic [7:0] CHR_LEFT_OUT  = 8'h3c;
    localparam logic [7:0] CHR_RIGHT_OUT = 8'h3e;

    // keys
    localparam logic [4:0] KEY_NONE       = 5'd0;
    localparam logic [4:0] KEY_MAX        = 5'd20;
    localparam logic [7:0] KEY_CANCEL_V1  = 8'h78;
    localparam logic [7:0] KEY_CANCEL_V2  = 8'h76;

    // panel variants
    localparam logic [1:0] MODEL_V1 = 2'd1;
    localparam logic [1:0] MODEL_V2 = 2'd2;

    // sizes
    localparam int MAX_STORE     = 32;
    localparam int STORE_AW      = $clog2(MAX_STORE);
    localparam int LCD_CELLS_DEF = 32;
    localparam int JOB_DEPTH_DEF = 2;

    // status led colours
    localparam logic [1:0] ST_OFF    = 2'd0;
    localparam logic [1:0] ST_GREEN  = 2'd1;
    localparam logic [1:0] ST_RED    = 2'd2;
    localparam logic [1:0] ST_YELLOW = 2'd3;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_CMD  = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        DISP_NONE = 2'd0,
        DISP_LCD  = 2'd1,
        DISP_LED  = 2'd2
    } disp_t;

    typedef enum logic [1:0] {
        RES_TX  = 2'd0,
        RES_LCD = 2'd1,
        RES_LED = 2'd2
    } res_kind_t;

    typedef enum logic [2:0] {
        BK_IDLE = 3'd0,
        BK_LCD  = 3'd1,
        BK_LED  = 3'd2,
        BK_KEY  = 3'd3,
        BK_ACK  = 3'd4,
        BK_NAK  = 3'd5
    } bk_state_t;

    // work handed from front to back
    typedef struct packed {
        logic       nak;
        disp_t      disp;
        logic [5:0] lcd_lim;
        logic [7:0] led_b1;
        logic [7:0] led_b2;
        logic       key_en;
        logic [7:0] key_tx;
    } job_t;

    // data store write port
    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } store_wr_t;

    typedef struct packed {
        logic       standby_on;
        logic [1:0] status_left;
        logic [1:0] status_right;
        logic       eco_on;
        logic       wps_on;
    } led_t;

    typedef struct packed {
        res_kind_t  kind;
        logic [7:0] tx_byte;
        logic [4:0] lcd_pos;
        logic [7:0] lcd_char;
        led_t       led;
        logic       last;
    } result_t;

    // colour of one status led from its green and red bits (active low)
    function automatic logic [1:0] status_of(logic [7:0] b, logic [7:0] gm, logic [7:0] rm);
        logic [1:0] st;
        if ((b & (gm | rm)) == 8'h00) begin
            st = ST_YELLOW;
        end else if ((b & gm) == 8'h00) begin
            st = ST_GREEN;
        end else if ((b & rm) == 8'h00) begin
            st = ST_RED;
        end else begin
            st = ST_OFF;
        end
        return st;
    endfunction

    function automatic led_t led_decode(logic [7:0] b1, logic [7:0] b2, logic second);
        led_t l;
        l.standby_on  = ((b2 & (second ? 8'h08 : 8'h01)) == 8'h00);
        l.status_left = status_of(b1, 8'h02, 8'h04);
        l.status_right = second ? status_of(b1, 8'h20, 8'h40) : status_of(b1, 8'h08, 8'h10);
        l.eco_on      = ((b1 & (second ? 8'h10 : 8'h20)) == 8'h00);
        l.wps_on      = ((b1 & (second ? 8'h08 : 8'h40)) == 8'h00);
        return l;
    endfunction

    // scan code sent for a panel key
    function automatic logic [7:0] key_byte(logic [4:0] key, logic second);
        logic [7:0] code;
        case (key)
            5'd1:  code = 8'h45;
            5'd2:  code = 8'h46;
            5'd3:  code = 8'h47;
            5'd4:  code = 8'h48;
            5'd5:  code = 8'h75;
            5'd6:  code = second ? KEY_CANCEL_V2 : KEY_CANCEL_V1;
            5'd7:  code = 8'h55;
            5'd8:  code = 8'h56;
            5'd9:  code = 8'h15;
            5'd10: code = 8'h25;
            5'd11: code = 8'h35;
            5'd12: code = 8'h16;
            5'd13: code = 8'h26;
            5'd14: code = 8'h36;
            5'd15: code = 8'h17;
            5'd16: code = 8'h27;
            5'd17: code = 8'h37;
            5'd18: code = 8'h18;
            5'd19: code = 8'h28;
            5'd20: code = 8'h38;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

// ===== design/opfe_front.sv =====
// ----------------------------------------------------------------------------
// opfe_front
// Accepts link words, tracks the frame, fills the data store and queues jobs.
// ----------------------------------------------------------------------------
module opfe_front #(
    parameter int LCD_CELLS = opfe_pkg::LCD_CELLS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                req_type,
    input  logic [7:0]          rx_byte,
    input  logic [4:0]          key_code,
    input  logic                second,
    input  logic                fifo_full,
    input  logic                back_busy,
    output logic                job_push,
    output opfe_pkg::job_t      job,
    output opfe_pkg::store_wr_t store_wr
);

    localparam int LIM_CAP = (LCD_CELLS < opfe_pkg::MAX_STORE) ? LCD_CELLS : opfe_pkg::MAX_STORE;

    opfe_pkg::phase_t phase_reg, phase_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] b1_reg, b1_next;
    logic [7:0] b2_reg, b2_next;
    logic       held_reg, held_next;

    logic       accept;
    logic       frame_end;
    logic       fin;
    logic       nak;
    logic       tmo_fin;
    logic [7:0] cnt_inc;

    // data words wait while the back end may still read the store
    assign s_tready = !fifo_full && !((phase_reg == opfe_pkg::PH_DATA) && back_busy);
    assign accept   = s_tvalid && s_tready;
    assign cnt_inc  = cnt_reg + 8'd1;

    // frame tracking and job build
    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        xor_next   = xor_reg;
        b1_next    = b1_reg;
        b2_next    = b2_reg;
        held_next  = held_reg;
        frame_end  = 1'b0;
        tmo_fin    = 1'b0;
        fin        = 1'b0;
        nak        = 1'b0;
        store_wr   = '0;
        job        = '0;

        if (accept) begin
            if (req_type) begin
                if (phase_reg == opfe_pkg::PH_HUNT) begin
                    tmo_fin = 1'b1;
                end else begin
                    nak = 1'b1;
                end
                phase_next = opfe_pkg::PH_HUNT;
            end else begin
                case (phase_reg)
                    opfe_pkg::PH_HUNT: begin
                        if (rx_byte == opfe_pkg::CODE_DC1) begin
                            phase_next = opfe_pkg::PH_CMD;
                        end
                    end
                    opfe_pkg::PH_CMD: begin
                        cmd_next   = rx_byte;
                        xor_next   = rx_byte;
                        phase_next = opfe_pkg::PH_LEN;
                    end
                    opfe_pkg::PH_LEN: begin
                        len_next = rx_byte;
                        xor_next = xor_reg ^ rx_byte;
                        cnt_next = 8'd0;
                        b1_next  = 8'd0;
                        b2_next  = 8'd0;
                        if (rx_byte == 8'd0) begin
                            frame_end  = 1'b1;
                            phase_next = opfe_pkg::PH_HUNT;
                        end else begin
                            phase_next = opfe_pkg::PH_DATA;
                        end
                    end
                    opfe_pkg::PH_DATA: begin
                        if (cnt_reg < 8'(opfe_pkg::MAX_STORE)) begin
                            store_wr.en   = 1'b1;
                            store_wr.addr = cnt_reg[opfe_pkg::STORE_AW-1:0];
                            store_wr.data = rx_byte;
                        end
                        xor_next = xor_reg ^ rx_byte;
                        cnt_next = cnt_inc;
                        if (cnt_reg == 8'd0) begin
                            b1_next = rx_byte;
                        end
                        if (cnt_reg == 8'd1) begin
                            b2_next = rx_byte;
                        end
                        if (cnt_inc >= len_reg) begin
                            frame_end  = 1'b1;
                            phase_next = opfe_pkg::PH_HUNT;
                        end
                    end
                    default: begin
                        phase_next = opfe_pkg::PH_HUNT;
                    end
                endcase
            end
        end

        // checksum verdict and display part of the job
        if (frame_end) begin
            if (xor_next != 8'd0) begin
                nak = 1'b1;
            end else begin
                fin = 1'b1;
                if (cmd_reg == opfe_pkg::OP_LCD) begin
                    job.disp    = opfe_pkg::DISP_LCD;
                    job.lcd_lim = (len_next > 8'(LIM_CAP)) ? 6'(LIM_CAP) : len_next[5:0];
                end else if (cmd_reg == opfe_pkg::OP_LED) begin
                    job.disp   = opfe_pkg::DISP_LED;
                    job.led_b1 = b1_next;
                    job.led_b2 = b2_next;
                end else if (cmd_reg == opfe_pkg::OP_RST) begin
                    job.disp = opfe_pkg::DISP_LED;
                end
            end
        end
        if (tmo_fin) begin
            fin = 1'b1;
        end

        // key press or release ahead of the ack
        if (fin) begin
            if (held_reg) begin
                job.key_en = 1'b1;
                job.key_tx = opfe_pkg::CODE_RELEASE;
                held_next  = 1'b0;
            end else if ((key_code != opfe_pkg::KEY_NONE) && (key_code <= opfe_pkg::KEY_MAX)) begin
                job.key_en = 1'b1;
                job.key_tx = opfe_pkg::key_byte(key_code, second);
                held_next  = 1'b1;
            end
        end

        job.nak  = nak;
        job_push = fin || nak;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= opfe_pkg::PH_HUNT;
            cmd_reg   <= 8'd0;
            len_reg   <= 8'd0;
            cnt_reg   <= 8'd0;
            xor_reg   <= 8'd0;
            held_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            xor_reg   <= xor_next;
            held_reg  <= held_next;
        end
    end

    // led bytes of the current frame
    always_ff @(posedge aclk) begin
        b1_reg <= b1_next;
        b2_reg <= b2_next;
    end

endmodule

// ===== design/opfe_job_fifo.sv =====
// ----------------------------------------------------------------------------
// opfe_job_fifo
// Short queue of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module opfe_job_fifo #(
    parameter int DEPTH = opfe_pkg::JOB_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  opfe_pkg::job_t push_data,
    input  logic           pop,
    output opfe_pkg::job_t pop_data,
    output logic           full,
    output logic           empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    opfe_pkg::job_t slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job slots
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/opfe_back.sv =====
// ----------------------------------------------------------------------------
// opfe_back
// Runs queued jobs: lcd writes from the data store, led update, key, ack/nak.
// ----------------------------------------------------------------------------
module opfe_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                second,
    input  opfe_pkg::store_wr_t store_wr,
    input  logic                fifo_empty,
    input  opfe_pkg::job_t      fifo_data,
    output logic                fifo_pop,
    output logic                busy,
    output logic                m_valid,
    input  logic                m_ready,
    output opfe_pkg::result_t   m_res
);

    opfe_pkg::bk_state_t state_reg, state_next;
    opfe_pkg::job_t      job_reg, job_next;
    logic [5:0]          idx_reg, idx_next;
    logic [7:0]          store_mem [opfe_pkg::MAX_STORE];
    logic [7:0]          rd_data_reg;
    logic                out_valid_reg;
    opfe_pkg::result_t   out_res_reg;
    logic                out_free;
    logic                emit;
    opfe_pkg::result_t   res;
    opfe_pkg::bk_state_t after_fifo;
    opfe_pkg::bk_state_t after_job;

    assign out_free   = !out_valid_reg || m_ready;
    assign busy       = !fifo_empty || (state_reg != opfe_pkg::BK_IDLE);
    assign after_fifo = fifo_data.key_en ? opfe_pkg::BK_KEY : opfe_pkg::BK_ACK;
    assign after_job  = job_reg.key_en ? opfe_pkg::BK_KEY : opfe_pkg::BK_ACK;
    assign m_valid    = out_valid_reg;
    assign m_res      = out_res_reg;

    // data store, read address follows the next lcd index
    always_ff @(posedge aclk) begin
        if (store_wr.en) begin
            store_mem[store_wr.addr] <= store_wr.data;
        end
        rd_data_reg <= store_mem[idx_next[opfe_pkg::STORE_AW-1:0]];
    end

    // job sequencer
    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        fifo_pop   = 1'b0;
        emit       = 1'b0;
        res        = '0;
        case (state_reg)
            opfe_pkg::BK_IDLE: begin
                if (!fifo_empty) begin
                    fifo_pop = 1'b1;
                    job_next = fifo_data;
                    idx_next = 6'd0;
                    if (fifo_data.nak) begin
                        state_next = opfe_pkg::BK_NAK;
                    end else begin
                        case (fifo_data.disp)
                            opfe_pkg::DISP_LCD: begin
                                state_next = (fifo_data.lcd_lim == 6'd0) ? after_fifo
                                                                         : opfe_pkg::BK_LCD;
                            end
                            opfe_pkg::DISP_LED: state_next = opfe_pkg::BK_LED;
                            default:            state_next = after_fifo;
                        endcase
                    end
                end
            end
            opfe_pkg::BK_LCD: begin
                if (rd_data_reg == 8'd0) begin
                    state_next = after_job;
                end else if (out_free) begin
                    emit         = 1'b1;
                    res.kind     = opfe_pkg::RES_LCD;
                    res.lcd_pos  = idx_reg[4:0];
                    if (rd_data_reg == opfe_pkg::CHR_LEFT_IN) begin
                        res.lcd_char = opfe_pkg::CHR_LEFT_OUT;
                    end else if (rd_data_reg == opfe_pkg::CHR_RIGHT_IN) begin
                        res.lcd_char = opfe_pkg::CHR_RIGHT_OUT;
                    end else begin
                        res.lcd_char = rd_data_reg;
                    end
                    idx_next = idx_reg + 6'd1;
                    if (idx_next == job_reg.lcd_lim) begin
                        state_next = after_job;
                    end
                end
            end
            opfe_pkg::BK_LED: begin
                if (out_free) begin
                    emit       = 1'b1;
                    res.kind   = opfe_pkg::RES_LED;
                    res.led    = opfe_pkg::led_decode(job_reg.led_b1, job_reg.led_b2, second);
                    state_next = after_job;
                end
            end
            opfe_pkg::BK_KEY: begin
                if (out_free) begin
                    emit        = 1'b1;
                    res.kind    = opfe_pkg::RES_TX;
                    res.tx_byte = job_reg.key_tx;
                    state_next  = opfe_pkg::BK_ACK;
                end
            end
            opfe_pkg::BK_ACK: begin
                if (out_free) begin
                    emit        = 1'b1;
                    res.kind    = opfe_pkg::RES_TX;
                    res.tx_byte = opfe_pkg::CODE_ACK;
                    res.last    = 1'b1;
                    state_next  = opfe_pkg::BK_IDLE;
                end
            end
            opfe_pkg::BK_NAK: begin
                if (out_free) begin
                    emit        = 1'b1;
                    res.kind    = opfe_pkg::RES_TX;
                    res.tx_byte = opfe_pkg::CODE_NAK;
                    res.last    = 1'b1;
                    state_next  = opfe_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = opfe_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= opfe_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // job, index and output word
    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        idx_reg <= idx_next;
        if (emit) begin
            out_res_reg <= res;
        end
    end

endmodule

// ===== design/operator_panel_frame_engine.sv =====
// ----------------------------------------------------------------------------
// operator_panel_frame_engine
// Panel side of an operator-panel serial link: frame receive, display decode,
// key reporting and ack/nak.
// ----------------------------------------------------------------------------
// Result path: with the back end idle, the first result word of an input word
//   passes the job queue, the back-end state and the output register to m_tvalid.
// Throughput: one input word per cycle while the job queue has room, but data
//   words wait while the back end still runs a job, since it reads the 32-byte
//   data store; a frame end yields up to 34 result words.
// Reset: aresetn clears frame, key and queue state, panel_model to 1; store kept.
module operator_panel_frame_engine #(
    parameter int LCD_CELLS = opfe_pkg::LCD_CELLS_DEF,
    parameter int JOB_DEPTH = opfe_pkg::JOB_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,   // panel_model
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // rx_byte[7:0], key_code[12:8], zero[15:13]
    input  logic [0:0]  s_tuser,       // req_type[0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // tx_byte[7:0], lcd_pos[12:8], lcd_char[20:13],
                                       // standby_on[21], status_left[23:22],
                                       // status_right[25:24], eco_on[26], wps_on[27],
                                       // zero[31:28]
    output logic [1:0]  m_tuser,       // result_kind[1:0]
    output logic        m_tlast        // last
);

    logic [1:0]          model_reg;
    logic                second;
    logic                fifo_full;
    logic                fifo_empty;
    logic                fifo_pop;
    logic                job_push;
    logic                back_busy;
    opfe_pkg::job_t      job_in;
    opfe_pkg::job_t      job_out;
    opfe_pkg::store_wr_t store_wr;
    opfe_pkg::result_t   out_res;

    // panel model register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            model_reg <= opfe_pkg::MODEL_V1;
        end else if (cfg_wr_en) begin
            model_reg <= cfg_wr_data;
        end
    end

    assign second = (model_reg == opfe_pkg::MODEL_V2);

    opfe_front #(
        .LCD_CELLS (LCD_CELLS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .req_type  (s_tuser[0]),
        .rx_byte   (s_tdata[7:0]),
        .key_code  (s_tdata[12:8]),
        .second    (second),
        .fifo_full (fifo_full),
        .back_busy (back_busy),
        .job_push  (job_push),
        .job       (job_in),
        .store_wr  (store_wr)
    );

    opfe_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (job_in),
        .pop       (fifo_pop),
        .pop_data  (job_out),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    opfe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .second     (second),
        .store_wr   (store_wr),
        .fifo_empty (fifo_empty),
        .fifo_data  (job_out),
        .fifo_pop   (fifo_pop),
        .busy       (back_busy),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_res      (out_res)
    );

    // result word packing
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;
    assign m_tdata = {4'b0000,
                      out_res.led.wps_on,
                      out_res.led.eco_on,
                      out_res.led.status_right,
                      out_res.led.status_left,
                      out_res.led.standby_on,
                      out_res.lcd_char,
                      out_res.lcd_pos,
                      out_res.tx_byte};

    // store is never written while the back end may read it
    a_store_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        store_wr.en |-> !back_busy)
        else $error("data store written while back end busy");

    // jobs are only queued with room in the queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        job_push |-> !fifo_full)
        else $error("job queued into a full queue");

    // lcd writes never carry a nul character
    a_lcd_not_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_res.kind == opfe_pkg::RES_LCD)) |-> (out_res.lcd_char != 8'd0))
        else $error("nul character written to lcd");

    // ack and nak always close the run of results
    a_ack_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_res.kind == opfe_pkg::RES_TX)
         && ((out_res.tx_byte == opfe_pkg::CODE_ACK) || (out_res.tx_byte == opfe_pkg::CODE_NAK)))
        |-> out_res.last)
        else $error("ack or nak not marked last");

endmodule
